>>> hw/rtl/multichannel_soft_pwm_top_assert.svh
// Assertion macros used by the top module to check its own logic.
`ifndef MULTICHANNEL_SOFT_PWM_TOP_ASSERT_SVH
`define MULTICHANNEL_SOFT_PWM_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msp assertion failed");

`endif

>>> hw/rtl/msp_pkg.sv
package msp_pkg;

  localparam int CHANNELS = 8;
  localparam int DutyW = 8;
  localparam int PhaseW = 8;
  localparam int LevelW = 8;
  localparam int ChanW = 3;
  localparam int PeriodW = 16;

  localparam logic [DutyW-1:0] ALWAYS_ON_DUTY = 8'hFF;
  localparam logic [PeriodW-1:0] PERIOD_RESET = 16'd390;

  localparam logic KindTick = 1'b0;
  localparam logic KindDuty = 1'b1;

  typedef struct packed {
    logic [0:0] kind;
    logic [ChanW-1:0] channel;
    logic [DutyW-1:0] duty;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] pwm_out;
    logic [0:0] period_elapsed;
    logic [PhaseW-1:0] phase;
  } out_item_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [LevelW-1:0] levels;
  } status_t;

endpackage

>>> hw/rtl/msp_in_stage.sv
module msp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  msp_pkg::in_item_t in_item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output msp_pkg::in_item_t item_o
);

  logic              valid_q, valid_d;
  msp_pkg::in_item_t item_q;

  assign in_stall_o = valid_q && !advance_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_i || !valid_q) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hw/rtl/msp_core.sv
module msp_core #(
  parameter int CHANNELS = msp_pkg::CHANNELS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [msp_pkg::PeriodW-1:0]  cfg_wdata_i,
  input  logic                         fire_i,
  input  msp_pkg::in_item_t            item_i,
  output msp_pkg::out_item_t           result_o,
  output msp_pkg::status_t             status_o
);

  logic [msp_pkg::PeriodW-1:0] ticks_q;
  logic [msp_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [msp_pkg::LevelW-1:0]  levels_q, levels_d;
  logic [msp_pkg::PeriodW-1:0] count_q, count_d;
  logic [msp_pkg::DutyW-1:0]   req_q [CHANNELS];
  logic [msp_pkg::DutyW-1:0]   req_d [CHANNELS];
  logic [msp_pkg::DutyW-1:0]   lat_q [CHANNELS];
  logic [msp_pkg::DutyW-1:0]   lat_d [CHANNELS];
  logic [msp_pkg::PeriodW:0]   count_inc;
  logic                        pulse;

  assign count_inc = {1'b0, count_q} + {{msp_pkg::PeriodW{1'b0}}, 1'b1};

  always_comb begin
    req_d    = req_q;
    lat_d    = lat_q;
    levels_d = levels_q;
    phase_d  = phase_q;
    count_d  = count_q;
    pulse    = 1'b0;
    if (fire_i) begin
      if (item_i.kind == msp_pkg::KindDuty) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (item_i.channel == msp_pkg::ChanW'(i)) begin
            req_d[i] = item_i.duty;
          end
        end
      end else begin
        if (phase_q == '0) begin
          for (int i = 0; i < CHANNELS; i++) begin
            lat_d[i] = req_q[i];
            if (req_q[i] != '0) begin
              levels_d[i] = 1'b1;
            end
          end
        end
        for (int i = 0; i < CHANNELS; i++) begin
          if (lat_d[i] == phase_q && lat_d[i] != msp_pkg::ALWAYS_ON_DUTY) begin
            levels_d[i] = 1'b0;
          end
        end
        if (count_inc >= {1'b0, ticks_q}) begin
          count_d = '0;
          pulse   = 1'b1;
        end else begin
          count_d = count_inc[msp_pkg::PeriodW-1:0];
        end
        phase_d = phase_q + msp_pkg::PhaseW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q  <= msp_pkg::PERIOD_RESET;
      phase_q  <= '0;
      levels_q <= '0;
      count_q  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        req_q[i] <= '0;
        lat_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
      phase_q  <= phase_d;
      levels_q <= levels_d;
      count_q  <= count_d;
      req_q    <= req_d;
      lat_q    <= lat_d;
    end
  end

  assign result_o.pwm_out        = levels_d;
  assign result_o.period_elapsed = pulse;
  assign result_o.phase          = phase_d;

  assign status_o.phase  = phase_q;
  assign status_o.levels = levels_q;

endmodule

>>> hw/rtl/multichannel_soft_pwm_top.sv
// Multichannel 8-bit PWM generator with a periodic pulse. Each input item is either a
// duty write for one channel or a timer tick, and every item yields exactly one result
// item holding the channel levels, the periodic pulse and the phase after that item.
// The block takes one item per clock cycle as long as the result side keeps up. An
// accepted item is held in the input register, passes the single logic stage of duty
// compares and counter updates, and is then offered from the result register. When a
// result waits under out_stall_i and the input register also holds an item, in_stall_o
// rises in that same cycle. New duties take effect at the next phase 0. periodic_ticks
// is written through cfg_we_i and cfg_wdata_i; the user must write it only while no
// item is in flight, and the block does not enforce this. A value of 0 behaves like 1.
`include "multichannel_soft_pwm_top_assert.svh"

module multichannel_soft_pwm_top #(
  parameter int CHANNELS = msp_pkg::CHANNELS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  msp_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output msp_pkg::out_item_t          out_item_o,
  input  logic                        cfg_we_i,
  input  logic [msp_pkg::PeriodW-1:0] cfg_wdata_i
);

  logic               s1_valid;
  msp_pkg::in_item_t  s1_item;
  logic               advance;
  msp_pkg::out_item_t result;
  msp_pkg::status_t   status;
  logic               out_valid_q, out_valid_d;
  msp_pkg::out_item_t out_item_q;

  assign advance = s1_valid && (!out_valid_q || !out_stall_i);

  msp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  msp_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (advance),
    .item_i      (s1_item),
    .result_o    (result),
    .status_o    (status)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `MSP_ASSERT_NOW(a_result_matches_state, clk_i, rst_ni, out_valid_q,
                  out_item_q.phase == status.phase && out_item_q.pwm_out == status.levels)
  `MSP_ASSERT_NEXT(a_tick_advances_phase, clk_i, rst_ni,
                   advance && s1_item.kind == msp_pkg::KindTick,
                   status.phase == msp_pkg::PhaseW'($past(status.phase) + 8'd1))
  `MSP_ASSERT_NOW(a_stall_needs_item, clk_i, rst_ni, in_stall_o,
                  s1_valid && out_valid_q && out_stall_i)

endmodule

>>> verif/multichannel_soft_pwm_checker.sv
`timescale 1ns / 1ps

module multichannel_soft_pwm_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  msp_pkg::in_item_t           in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  msp_pkg::out_item_t          out_item_i,
  input  logic                        cfg_we_i,
  input  logic [msp_pkg::PeriodW-1:0] cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  logic [msp_pkg::PhaseW-1:0]  phase_q;
  logic [msp_pkg::DutyW-1:0]   duty_req [msp_pkg::CHANNELS];
  logic [msp_pkg::DutyW-1:0]   duty_lat [msp_pkg::CHANNELS];
  logic [msp_pkg::LevelW-1:0]  levels_q;
  logic [msp_pkg::PeriodW-1:0] tick_count;
  logic [msp_pkg::PeriodW-1:0] period_ticks;
  msp_pkg::out_item_t          expected_levels[$];
  int                          fails;

  function automatic msp_pkg::out_item_t pwm_next(msp_pkg::in_item_t item);
    msp_pkg::out_item_t           res;
    logic [msp_pkg::LevelW-1:0]   lv;
    logic [msp_pkg::PeriodW:0]    next_count;
    res = '0;
    if (item.kind == msp_pkg::KindDuty) begin
      if (int'(item.channel) < msp_pkg::CHANNELS) begin
        duty_req[item.channel] = item.duty;
      end
    end else begin
      lv = levels_q;
      if (phase_q == '0) begin
        for (int i = 0; i < msp_pkg::CHANNELS; i++) begin
          duty_lat[i] = duty_req[i];
          if (duty_lat[i] != '0) begin
            lv[i] = 1'b1;
          end
        end
      end
      for (int i = 0; i < msp_pkg::CHANNELS; i++) begin
        if (duty_lat[i] == phase_q && duty_lat[i] != msp_pkg::ALWAYS_ON_DUTY) begin
          lv[i] = 1'b0;
        end
      end
      levels_q = lv;
      next_count = {1'b0, tick_count} + (msp_pkg::PeriodW + 1)'(1);
      if (next_count >= {1'b0, period_ticks}) begin
        tick_count = '0;
        res.period_elapsed = 1'b1;
      end else begin
        tick_count = next_count[msp_pkg::PeriodW-1:0];
      end
      phase_q = phase_q + msp_pkg::PhaseW'(1);
    end
    res.pwm_out = levels_q;
    res.phase = phase_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    msp_pkg::out_item_t want;
    if (!rst_ni) begin
      phase_q = '0;
      levels_q = '0;
      tick_count = '0;
      period_ticks = msp_pkg::PERIOD_RESET;
      for (int i = 0; i < msp_pkg::CHANNELS; i++) begin
        duty_req[i] = '0;
        duty_lat[i] = '0;
      end
      expected_levels.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        period_ticks = cfg_wdata_i;
      end
      // Results leave before new items enter, so an item accepted at this edge
      // is never matched against a result leaving at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_levels.size() == 0) begin
          $error("result item arrived with no item outstanding");
          fails++;
        end else begin
          want = expected_levels.pop_front();
          if (out_item_i.pwm_out !== want.pwm_out) begin
            $error("pwm_out expected %02h actual %02h", want.pwm_out, out_item_i.pwm_out);
            fails++;
          end
          if (out_item_i.period_elapsed !== want.period_elapsed) begin
            $error("period_elapsed expected %0b actual %0b",
                   want.period_elapsed, out_item_i.period_elapsed);
            fails++;
          end
          if (out_item_i.phase !== want.phase) begin
            $error("phase expected %0d actual %0d", want.phase, out_item_i.phase);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_levels.push_back(pwm_next(in_item_i));
      end
    end
    fail_count_o <= fails;
    pending_o <= expected_levels.size();
  end

endmodule

>>> verif/multichannel_soft_pwm_top_test.sv
`timescale 1ns / 1ps

module multichannel_soft_pwm_top_test;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 200;
  localparam int PHASES = 8;
  localparam int LONG_HOLD = 60;
  localparam int END_CYCLES = 6;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  msp_pkg::in_item_t           in_item_i;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  msp_pkg::out_item_t          out_item_o;
  logic                        cfg_we_i;
  logic [msp_pkg::PeriodW-1:0] cfg_wdata_i;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  multichannel_soft_pwm_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  multichannel_soft_pwm_checker pwm_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multichannel_soft_pwm_top verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic offer_item(logic kind, logic [2:0] channel, logic [7:0] duty);
    msp_pkg::in_item_t item;
    item.kind = kind;
    item.channel = channel;
    item.duty = duty;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= item;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_period(logic [msp_pkg::PeriodW-1:0] ticks);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_duty();
    logic [7:0] corner [4];
    corner = '{8'h00, 8'h01, 8'hFE, 8'hFF};
    if ($urandom_range(0, 3) == 0) begin
      return corner[$urandom_range(0, 3)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [7:0] first_duties [8];
    logic [msp_pkg::PeriodW-1:0] phase_period [PHASES];
    first_duties = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h02, 8'h55, 8'hAA};
    phase_period = '{16'd1, 16'hFFFF, 16'd5, 16'd0, 16'd256, msp_pkg::PERIOD_RESET,
                     16'd17, 16'd1};
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every channel gets a fixed duty, corner values among them, then ticks walk
    // the first phases, with duty writes landing in the middle of the cycle.
    for (int ch = 0; ch < 8; ch++) begin
      offer_item(msp_pkg::KindDuty, 3'(ch), first_duties[ch]);
    end
    offer_item(msp_pkg::KindTick, 3'd7, 8'hFF);
    offer_item(msp_pkg::KindTick, 3'd0, 8'h00);
    offer_item(msp_pkg::KindTick, 3'd0, 8'h00);
    offer_item(msp_pkg::KindDuty, 3'd0, 8'hFF);
    offer_item(msp_pkg::KindTick, 3'd0, 8'h00);
    offer_item(msp_pkg::KindDuty, 3'd3, 8'h00);
    offer_item(msp_pkg::KindTick, 3'd0, 8'h00);

    // A zero period pulses on every tick.
    set_period('0);
    repeat (3) offer_item(msp_pkg::KindTick, 3'd0, 8'h00);

    // Lowering the period below the running count pulses on the next tick.
    set_period(16'd100);
    repeat (6) offer_item(msp_pkg::KindTick, 3'd0, 8'h00);
    set_period(16'd3);
    repeat (2) offer_item(msp_pkg::KindTick, 3'd0, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        set_period(16'($urandom_range(1, 300)));
      end else begin
        set_period(phase_period[p]);
      end
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 77;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 77;
        end
        default: begin
          idle_pct = 15;
          stall_pct = 15;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p % 4 == 0 && n == 50) begin
          hold_asked++;
        end
        if ($urandom_range(0, 99) < 80) begin
          offer_item(msp_pkg::KindTick, 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)));
        end else begin
          offer_item(msp_pkg::KindDuty, 3'($urandom_range(0, 7)), pick_duty());
        end
      end
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("multichannel_soft_pwm_top verification clean");
    end else begin
      $display("multichannel_soft_pwm_top verification failed");
    end
    $finish;
  end

endmodule
